// ----- rtl/ntpi_pkg.sv -----
// Shared constants and the exp2 table generator for the note to phase increment core.
package ntpi_pkg;

	localparam int unsigned NOTE_BITS_DEF  = 16;
	localparam int unsigned FINE_STEPS_DEF = 256;
	localparam int unsigned SEMIS          = 12;
	localparam int unsigned SEMI_W         = 4;
	localparam int unsigned FRAC_BITS      = 24;
	localparam int unsigned MANT_W         = 25;
	localparam int unsigned INC_W          = 32;
	localparam int unsigned PROD_W         = INC_W + MANT_W;
	localparam int unsigned SHIFT_W        = 6;
	localparam int unsigned BIG_OCT        = 40;
	localparam int unsigned EXP_TERMS      = 24;

	localparam logic [63:0]      LN2_Q32        = 64'd2977044472;
	localparam logic [INC_W-1:0] NYQUIST        = 32'h8000_0000;
	localparam logic [INC_W-1:0] BASE_INC_RESET = 32'd374557700;

	// 2^x in Q24 from y = x * ln2 in Q32, via the exp series in Q32
	function automatic logic [MANT_W-1:0] exp2_q24(input logic [63:0] y);
		logic [63:0] sum;
		logic [63:0] term;
		sum  = 64'd1 << 32;
		term = 64'd1 << 32;
		for (int k = 1; k <= EXP_TERMS; k++) begin
			term = (((term * y) >> 32) + 64'(k / 2)) / 64'(k);
			sum  = sum + term;
		end
		return MANT_W'((sum + 64'd128) >> 8);
	endfunction

endpackage

// ----- rtl/note_to_phase_increment_core.sv -----
// Top level of the note to phase increment core: stream ports, base register, pipeline.
// A note (1/FINE_STEPS semitone steps above C(-8)) becomes the rounded phase step of a
// 32-bit accumulator, base_increment * 2^(note / (12*FINE_STEPS)) / 2^16, clamped at 2^31
// with m_tuser set when clamped. One note is accepted per clock unless the output stalls.
// The eight register stages are octave estimate, octave correction, semitone split, table
// read, mantissa product, base product, octave shift, round and clamp. Each stage holds only
// while its successor is full, so a stalled output still lets notes in until the pipeline
// fills. The user must write base_increment through the cfg channel while idle; not enforced.
module note_to_phase_increment_core
	import ntpi_pkg::*;
#(
	parameter int unsigned NOTE_BITS = NOTE_BITS_DEF,
	parameter int unsigned FINE_STEPS = FINE_STEPS_DEF,
	localparam int unsigned IN_W = ((NOTE_BITS + 7) / 8) * 8,
	localparam int unsigned PER_OCT = SEMIS * FINE_STEPS,
	localparam int unsigned OCT_MAX = ((1 << NOTE_BITS) - 1) / PER_OCT,
	localparam int unsigned OCT_W = (OCT_MAX > 0) ? $clog2(OCT_MAX + 1) : 1,
	localparam int unsigned FINE_W = $clog2(FINE_STEPS)
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_tvalid,
	output logic             s_tready,
	input  logic [IN_W-1:0]  s_tdata,   // note
	output logic             m_tvalid,
	input  logic             m_tready,
	output logic [INC_W-1:0] m_tdata,   // phase_increment
	output logic             m_tuser,   // at_nyquist
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  logic [INC_W-1:0] cfg_data   // base_increment
);

	logic [INC_W-1:0]  base_increment_q;

	logic              sp_valid, sp_ready;
	logic [OCT_W-1:0]  sp_oct;
	logic [SEMI_W-1:0] sp_semi;
	logic [FINE_W-1:0] sp_fine;

	logic              lk_valid, lk_ready;
	logic [OCT_W-1:0]  lk_oct;
	logic [MANT_W-1:0] lk_semi_val;
	logic [MANT_W-1:0] lk_fine_val;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_increment_q <= BASE_INC_RESET;
		end else if (cfg_valid && cfg_ready) begin
			base_increment_q <= cfg_data;
		end
	end

	ntpi_split #(
		.NOTE_BITS (NOTE_BITS),
		.FINE_STEPS(FINE_STEPS)
	) u_split (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.note     (s_tdata[NOTE_BITS-1:0]),
		.out_valid(sp_valid),
		.out_ready(sp_ready),
		.oct      (sp_oct),
		.semi     (sp_semi),
		.fine     (sp_fine)
	);

	ntpi_lookup #(
		.FINE_STEPS(FINE_STEPS),
		.OCT_W     (OCT_W)
	) u_lookup (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (sp_valid),
		.in_ready (sp_ready),
		.oct      (sp_oct),
		.semi     (sp_semi),
		.fine     (sp_fine),
		.out_valid(lk_valid),
		.out_ready(lk_ready),
		.oct_out  (lk_oct),
		.semi_val (lk_semi_val),
		.fine_val (lk_fine_val)
	);

	ntpi_scale #(
		.OCT_W(OCT_W)
	) u_scale (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (lk_valid),
		.in_ready       (lk_ready),
		.oct            (lk_oct),
		.semi_val       (lk_semi_val),
		.fine_val       (lk_fine_val),
		.base           (base_increment_q),
		.out_valid      (m_tvalid),
		.out_ready      (m_tready),
		.phase_increment(m_tdata),
		.at_nyquist     (m_tuser)
	);

	a_clamp_value: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> m_tdata == NYQUIST)
		else $error("clamp flag set without the half-rate value");

	a_result_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata <= NYQUIST)
		else $error("phase increment above half the sample rate");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> m_tvalid && !m_tready)
		else $error("input held while the output is not backpressured");

	a_cfg_write: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid && cfg_ready |=> base_increment_q == $past(cfg_data))
		else $error("base increment write lost");

endmodule

// ----- rtl/ntpi_exp2_rom.sv -----
// Constant exp2 fraction table in Q24 with a registered read port.
module ntpi_exp2_rom
	import ntpi_pkg::*;
#(
	parameter int unsigned DEPTH = SEMIS,
	parameter int unsigned DEN = SEMIS,
	localparam int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic              clk,
	input  logic              en,
	input  logic [ADDR_W-1:0] addr,
	output logic [MANT_W-1:0] rdata
);

	logic [MANT_W-1:0] tab [DEPTH];
	logic [MANT_W-1:0] rdata_q;

	for (genvar i = 0; i < DEPTH; i++) begin : g_tab
		localparam logic [63:0] Y = (64'(i) * LN2_Q32 + 64'(DEN / 2)) / 64'(DEN);
		localparam logic [MANT_W-1:0] VAL = exp2_q24(Y);
		assign tab[i] = VAL;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rdata_q <= tab[addr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ----- rtl/ntpi_split.sv -----
// Three-stage split of a note into octave, semitone and fine step.
module ntpi_split
	import ntpi_pkg::*;
#(
	parameter int unsigned NOTE_BITS = NOTE_BITS_DEF,
	parameter int unsigned FINE_STEPS = FINE_STEPS_DEF,
	localparam int unsigned PER_OCT = SEMIS * FINE_STEPS,
	localparam int unsigned OCT_MAX = ((1 << NOTE_BITS) - 1) / PER_OCT,
	localparam int unsigned OCT_W = (OCT_MAX > 0) ? $clog2(OCT_MAX + 1) : 1,
	localparam int unsigned REM_W = $clog2(PER_OCT),
	localparam int unsigned FINE_W = $clog2(FINE_STEPS),
	localparam int unsigned RECIP = (1 << NOTE_BITS) / PER_OCT
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [NOTE_BITS-1:0] note,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [OCT_W-1:0]     oct,
	output logic [SEMI_W-1:0]    semi,
	output logic [FINE_W-1:0]    fine
);

	logic vld_s1, vld_s2, vld_s3;
	logic en1, en2, en3;

	logic [NOTE_BITS-1:0]   note_s1;
	logic [OCT_W-1:0]       qe_s1;
	logic [OCT_W-1:0]       oct_s2, oct_s3;
	logic [REM_W-1:0]       rem_s2;
	logic [SEMI_W-1:0]      semi_s3;
	logic [FINE_W-1:0]      fine_s3;

	logic [2*NOTE_BITS-1:0] qprod;
	logic [31:0]            rem_raw;
	logic                   rem_fix;
	logic [31:0]            rem_adj;
	logic [SEMI_W-1:0]      semi_c;
	logic [31:0]            off_c;

	assign en3      = !vld_s3 || out_ready;
	assign en2      = !vld_s2 || en3;
	assign en1      = !vld_s1 || en2;
	assign in_ready = en1;

	assign qprod = (2*NOTE_BITS)'(note) * (2*NOTE_BITS)'(RECIP);

	assign rem_raw = 32'(note_s1) - 32'(qe_s1) * 32'(PER_OCT);
	assign rem_fix = rem_raw >= 32'(PER_OCT);
	assign rem_adj = rem_fix ? rem_raw - 32'(PER_OCT) : rem_raw;

	always_comb begin
		semi_c = '0;
		off_c  = '0;
		for (int k = 1; k < SEMIS; k++) begin
			if (32'(rem_s2) >= 32'(k * FINE_STEPS)) begin
				semi_c = SEMI_W'(k);
				off_c  = 32'(k * FINE_STEPS);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else begin
			if (en1) vld_s1 <= in_valid;
			if (en2) vld_s2 <= vld_s1;
			if (en3) vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en1) begin
			note_s1 <= note;
			qe_s1   <= qprod[NOTE_BITS +: OCT_W];
		end
		if (en2) begin
			oct_s2 <= qe_s1 + OCT_W'(rem_fix);
			rem_s2 <= REM_W'(rem_adj);
		end
		if (en3) begin
			oct_s3  <= oct_s2;
			semi_s3 <= semi_c;
			fine_s3 <= FINE_W'(32'(rem_s2) - off_c);
		end
	end

	assign out_valid = vld_s3;
	assign oct       = oct_s3;
	assign semi      = semi_s3;
	assign fine      = fine_s3;

endmodule

// ----- rtl/ntpi_lookup.sv -----
// Table stage: semitone and fine factors from the exp2 tables.
module ntpi_lookup
	import ntpi_pkg::*;
#(
	parameter int unsigned FINE_STEPS = FINE_STEPS_DEF,
	parameter int unsigned OCT_W = 1,
	localparam int unsigned FINE_W = $clog2(FINE_STEPS)
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [OCT_W-1:0]  oct,
	input  logic [SEMI_W-1:0] semi,
	input  logic [FINE_W-1:0] fine,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [OCT_W-1:0]  oct_out,
	output logic [MANT_W-1:0] semi_val,
	output logic [MANT_W-1:0] fine_val
);

	logic             vld_s4;
	logic             en4;
	logic [OCT_W-1:0] oct_s4;

	assign en4      = !vld_s4 || out_ready;
	assign in_ready = en4;

	ntpi_exp2_rom #(
		.DEPTH(SEMIS),
		.DEN  (SEMIS)
	) u_semi_rom (
		.clk  (clk),
		.en   (en4),
		.addr (semi),
		.rdata(semi_val)
	);

	ntpi_exp2_rom #(
		.DEPTH(FINE_STEPS),
		.DEN  (SEMIS * FINE_STEPS)
	) u_fine_rom (
		.clk  (clk),
		.en   (en4),
		.addr (fine),
		.rdata(fine_val)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s4 <= 1'b0;
		end else if (en4) begin
			vld_s4 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en4) begin
			oct_s4 <= oct;
		end
	end

	assign out_valid = vld_s4;
	assign oct_out   = oct_s4;

endmodule

// ----- rtl/ntpi_scale.sv -----
// Four-stage mantissa product, base scaling, octave shift and clamp to half the sample rate.
module ntpi_scale
	import ntpi_pkg::*;
#(
	parameter int unsigned OCT_W = 1
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [OCT_W-1:0]  oct,
	input  logic [MANT_W-1:0] semi_val,
	input  logic [MANT_W-1:0] fine_val,
	input  logic [INC_W-1:0]  base,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [INC_W-1:0]  phase_increment,
	output logic              at_nyquist
);

	logic vld_s5, vld_s6, vld_s7, vld_s8;
	logic en5, en6, en7, en8;

	logic [OCT_W-1:0]    oct_s5, oct_s6;
	logic [MANT_W-1:0]   m_s5;
	logic [PROD_W-1:0]   p_s6;
	logic [PROD_W-1:0]   t_s7;
	logic                big_s7;
	logic                pnz_s7;
	logic [INC_W-1:0]    phase_s8;
	logic                nyq_s8;

	logic [2*MANT_W-1:0] mprod;
	logic [2*MANT_W-1:0] mround;
	logic                big_c;
	logic [SHIFT_W-1:0]  sh_c;
	logic [INC_W-1:0]    phase_c;
	logic                nyq_c;

	assign en8      = !vld_s8 || out_ready;
	assign en7      = !vld_s7 || en8;
	assign en6      = !vld_s6 || en7;
	assign en5      = !vld_s5 || en6;
	assign in_ready = en5;

	assign mprod  = (2*MANT_W)'(semi_val) * (2*MANT_W)'(fine_val);
	assign mround = mprod + ((2*MANT_W)'(1) << (FRAC_BITS - 1));

	assign big_c = 32'(oct_s6) >= 32'(BIG_OCT);
	assign sh_c  = big_c ? '0 : SHIFT_W'(32'(BIG_OCT - 1) - 32'(oct_s6));

	always_comb begin
		if (big_s7) begin
			phase_c = pnz_s7 ? NYQUIST : '0;
			nyq_c   = pnz_s7;
		end else if (t_s7 >= PROD_W'({INC_W{1'b1}})) begin
			phase_c = NYQUIST;
			nyq_c   = 1'b1;
		end else begin
			phase_c = {1'b0, t_s7[INC_W-1:1]} + INC_W'(t_s7[0]);
			nyq_c   = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
			vld_s7 <= 1'b0;
			vld_s8 <= 1'b0;
		end else begin
			if (en5) vld_s5 <= in_valid;
			if (en6) vld_s6 <= vld_s5;
			if (en7) vld_s7 <= vld_s6;
			if (en8) vld_s8 <= vld_s7;
		end
	end

	always_ff @(posedge clk) begin
		if (en5) begin
			oct_s5 <= oct;
			m_s5   <= mround[FRAC_BITS +: MANT_W];
		end
		if (en6) begin
			oct_s6 <= oct_s5;
			p_s6   <= PROD_W'(base) * PROD_W'(m_s5);
		end
		if (en7) begin
			t_s7   <= p_s6 >> sh_c;
			big_s7 <= big_c;
			pnz_s7 <= |p_s6;
		end
		if (en8) begin
			phase_s8 <= phase_c;
			nyq_s8   <= nyq_c;
		end
	end

	assign out_valid       = vld_s8;
	assign phase_increment = phase_s8;
	assign at_nyquist      = nyq_s8;

endmodule
